/* hdl/assert_macros.svh */
// Assertion macros used by the top level of the mode frequency tracker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define WMFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define WMFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/wmft_pkg.sv */
// Shared types and constants for the window mode frequency tracker.
// No dependencies; imported by the controller, datapath and top level.
package wmft_pkg;

  localparam int DefSymbolCount = 1024;
  localparam int DefCountLimit  = 1024;

  localparam int ModeW   = 11;
  localparam int StatusW = 2;
  localparam int SymbolW = 10;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_LIMIT  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture word, read symbol count
    logic clr_step;  // zero one entry of each store
    logic lookup;    // read the two histogram bins
    logic emit_ign;  // deliver an ignored result
    logic commit;    // write count, old bin and top count
    logic finish;    // write new bin, deliver ok result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ignore;    // current word leaves the state untouched
    logic clr_last;  // clearing pass is at its last entry
  } stat_t;

endpackage

/* hdl/wmft_ctrl.sv */
// Sequencer of the mode frequency tracker: clearing pass and item steps.
// Depends on wmft_pkg.
module wmft_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  wmft_pkg::stat_t stat_i,
  output wmft_pkg::cmd_t  cmd_o,
  output logic            busy
);
  import wmft_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CNT   = 5'b00100,
    S_HIST  = 5'b01000,
    S_WRNEW = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_CNT;
        end
      end
      S_CNT: begin
        if (stat_i.ignore) begin
          cmd_o.emit_ign = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.lookup = 1'b1;
          state_d      = S_HIST;
        end
      end
      S_HIST: begin
        cmd_o.commit = 1'b1;
        state_d      = S_WRNEW;
      end
      S_WRNEW: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

/* hdl/wmft_dp.sv */
// Datapath of the mode frequency tracker: count and histogram memories,
// top count and result registers. Depends on wmft_pkg.
module wmft_dp #(
  parameter int SYMBOL_COUNT = wmft_pkg::DefSymbolCount,
  parameter int COUNT_LIMIT  = wmft_pkg::DefCountLimit
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wmft_pkg::cmd_t                cmd_i,
  output wmft_pkg::stat_t               stat_o,
  input  logic                          opcode_i,
  input  logic [wmft_pkg::SymbolW-1:0]  symbol_i,
  output logic                          done_o,
  output logic [wmft_pkg::ModeW-1:0]    mode_frequency_o,
  output logic [wmft_pkg::StatusW-1:0]  status_o
);
  import wmft_pkg::*;

  localparam int SymAw  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int CntW   = $clog2(COUNT_LIMIT + 1);
  localparam int HistW  = $clog2(SYMBOL_COUNT + 1);
  localparam int HistN  = COUNT_LIMIT + 1;
  localparam int ClrN   = (SYMBOL_COUNT > HistN) ? SYMBOL_COUNT : HistN;
  localparam int ClrW   = $clog2(ClrN);

  logic [CntW-1:0]  cnt_mem  [SYMBOL_COUNT];
  logic [HistW-1:0] hist_mem [HistN];

  logic                op_q;
  logic [SymbolW-1:0]  sym_q;
  logic [CntW-1:0]     cnt_rd_q;
  logic [HistW-1:0]    hold_rd_q, hnb_rd_q;
  logic [CntW-1:0]     top_q, top_d;
  logic [ClrW-1:0]     clr_q;
  logic                done_q;
  logic [ModeW-1:0]    mode_q;
  logic [StatusW-1:0]  status_q;

  logic                in_range;
  logic [CntW-1:0]     cnt_nb;
  logic                cnt_we, hist_we;
  logic [SymAw-1:0]    cnt_wa;
  logic [CntW-1:0]     cnt_wd;
  logic [CntW-1:0]     hist_wa;
  logic [HistW-1:0]    hist_wd;
  logic                clr_in_cnt, clr_in_hist;

  assign in_range = (32'(sym_q) < SYMBOL_COUNT);
  // Neighbor bin: one above for an add, one below for a removal.
  assign cnt_nb   = op_q ? (cnt_rd_q - 1'b1) : (cnt_rd_q + 1'b1);

  assign stat_o.ignore   = !in_range ||
                           (op_q ? (cnt_rd_q == '0) : (32'(cnt_rd_q) >= COUNT_LIMIT));
  assign stat_o.clr_last = (clr_q == ClrW'(ClrN - 1));

  assign clr_in_cnt  = (32'(clr_q) < SYMBOL_COUNT);
  assign clr_in_hist = (32'(clr_q) < HistN);

  always_comb begin
    cnt_we  = 1'b0;
    cnt_wa  = SymAw'(sym_q);
    cnt_wd  = cnt_nb;
    hist_we = 1'b0;
    hist_wa = cnt_rd_q;
    hist_wd = hold_rd_q - 1'b1;
    if (cmd_i.clr_step) begin
      cnt_we  = clr_in_cnt;
      cnt_wa  = SymAw'(clr_q);
      cnt_wd  = '0;
      hist_we = clr_in_hist;
      hist_wa = CntW'(clr_q);
      hist_wd = '0;
    end else if (cmd_i.commit) begin
      cnt_we  = 1'b1;
      // bin zero is never tracked
      hist_we = op_q || (cnt_rd_q != '0);
    end else if (cmd_i.finish) begin
      hist_we = !op_q || (cnt_nb != '0);
      hist_wa = cnt_nb;
      hist_wd = hnb_rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd_i.load) begin
      cnt_rd_q <= cnt_mem[SymAw'(symbol_i)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (cmd_i.lookup) begin
      hold_rd_q <= hist_mem[cnt_rd_q];
      hnb_rd_q  <= hist_mem[cnt_nb];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      sym_q <= symbol_i;
    end
  end

  always_comb begin
    top_d = top_q;
    if (cmd_i.commit) begin
      if (!op_q) begin
        if (cnt_nb > top_q) begin
          top_d = cnt_nb;
        end
      end else if ((cnt_rd_q == top_q) && (hold_rd_q == HistW'(1))) begin
        // last symbol at the top count drops
        top_d = top_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      clr_q  <= '0;
      done_q <= 1'b0;
    end else begin
      top_q  <= top_d;
      done_q <= cmd_i.emit_ign || cmd_i.finish;
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ign || cmd_i.finish) begin
      mode_q <= ModeW'(top_q);
    end
    if (cmd_i.emit_ign) begin
      status_q <= op_q ? ST_ABSENT : ST_LIMIT;
    end else if (cmd_i.finish) begin
      status_q <= ST_OK;
    end
  end

  assign done_o           = done_q;
  assign mode_frequency_o = mode_q;
  assign status_o         = status_q;

endmodule

/* hdl/window_mode_frequency_tracker_top.sv */
// Top level of the window mode frequency tracker.
// Depends on wmft_pkg, wmft_ctrl, wmft_dp and assert_macros.svh.
//
// Use: raise start with opcode_i (0 add, 1 remove) and symbol_i; the word is
// taken at a rising edge where start is high and busy is low. Each word gives
// one result on mode_frequency_o and status_o, shown for one cycle with
// done_o high. The receiver cannot stall; results must be taken as shown.
// Sequence: done_o rises after the count read and check for an ignored word
// (absent symbol removal, add at the count limit, symbol beyond the store)
// and after the lookup, commit and new-bin write for an applied word. A new
// word is taken at the edge that ends the result cycle, so words never
// overlap. The four steps of an applied word come from the read-modify-write
// of the count memory followed by two read-modify-writes of the histogram
// memory, whose single write port takes one bin per cycle.
// Reset: all stores are cleared by a pass over max(SYMBOL_COUNT,
// COUNT_LIMIT+1) entries (1025 by default); busy stays high until it ends.
`include "assert_macros.svh"
module window_mode_frequency_tracker_top #(
  parameter int SYMBOL_COUNT = wmft_pkg::DefSymbolCount,
  parameter int COUNT_LIMIT  = wmft_pkg::DefCountLimit
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          opcode_i,
  input  logic [wmft_pkg::SymbolW-1:0]  symbol_i,
  output logic                          done_o,
  output logic [wmft_pkg::ModeW-1:0]    mode_frequency_o,
  output logic [wmft_pkg::StatusW-1:0]  status_o
);
  import wmft_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  wmft_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  wmft_dp #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .COUNT_LIMIT  (COUNT_LIMIT)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .opcode_i         (opcode_i),
    .symbol_i         (symbol_i),
    .done_o           (done_o),
    .mode_frequency_o (mode_frequency_o),
    .status_o         (status_o)
  );

  `WMFT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "busy not raised")
  `WMFT_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy, "result shown while busy")
  `WMFT_ASSERT_NOW(a_done_after_work, clk_i, rst_ni, done_o, $past(busy), "stray result")
  `WMFT_ASSERT_NOW(a_clear_quiet, clk_i, rst_ni, cmd.clr_step, !done_o && !cmd.load, "clear active")

endmodule
